/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define IMT_ASSERT_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define IMT_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* sv/imt_pkg.sv */
// ----------------------------------------------------------------------------
// imt_pkg
// Sizes, codes and item types of the in-place matrix transpose.
// ----------------------------------------------------------------------------
package imt_pkg;

	localparam int CAPACITY  = 1024;
	localparam int ELEM_W    = 32;
	localparam int FIELD_W   = 32;
	localparam int REG_W     = 11;
	localparam int ADDR_W    = $clog2(CAPACITY);
	localparam int POS_W     = $clog2(CAPACITY + 1);
	localparam int PROD_W    = 2 * REG_W;
	localparam int DIV_CNT_W = (ADDR_W > 1) ? $clog2(ADDR_W) : 1;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_COLS = CFG_IDX_W'(1);

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_READ = 1'b1
	} action_t;

	typedef struct packed {
		action_t              action;
		logic [FIELD_W-1:0]   element_in;
	} req_t;

	typedef struct packed {
		logic [FIELD_W-1:0]   element_out;
		logic                 last_of_matrix;
	} rsp_t;

	typedef struct packed {
		logic [REG_W-1:0] rows;
		logic [REG_W-1:0] cols;
	} shape_t;

	typedef struct packed {
		logic              go;
		logic [ADDR_W-1:0] k;
	} ix_req_t;

	typedef struct packed {
		logic              done;
		logic [ADDR_W-1:0] next;
	} ix_rsp_t;

endpackage

/* sv/imt_index_unit.sv */
// ----------------------------------------------------------------------------
// imt_index_unit
// Shared index unit: next(k) = (k mod cols) * rows + k div cols, by a
// restoring divider (one quotient bit a cycle) and a registered multiply-add.
// ----------------------------------------------------------------------------
module imt_index_unit import imt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  shape_t  shape,
	input  ix_req_t req,
	output ix_rsp_t rsp
);

	typedef enum logic [2:0] {
		IX_IDLE = 3'b001,
		IX_DIV  = 3'b010,
		IX_MUL  = 3'b100
	} ix_state_t;

	ix_state_t             state_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [ADDR_W-1:0]     dq_q;
	logic [REG_W-1:0]      rem_q;
	logic                  done_q;
	logic [ADDR_W-1:0]     next_q;

	logic [REG_W:0]        trial;
	logic [REG_W:0]        diff;
	logic                  ge;
	logic [REG_W-1:0]      rem_d;
	logic [PROD_W-1:0]     prod;
	logic [PROD_W-1:0]     sum;

	always_comb begin
		trial = {rem_q, dq_q[ADDR_W-1]};
		ge    = trial >= {1'b0, shape.cols};
		diff  = trial - {1'b0, shape.cols};
		rem_d = ge ? diff[REG_W-1:0] : trial[REG_W-1:0];
		prod  = PROD_W'(rem_q) * PROD_W'(shape.rows);
		sum   = prod + PROD_W'(dq_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IX_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				IX_IDLE: begin
					done_q <= 1'b0;
					if (req.go) begin
						cnt_q   <= DIV_CNT_W'(ADDR_W - 1);
						state_q <= IX_DIV;
					end
				end
				IX_DIV: begin
					if (cnt_q == '0) begin
						state_q <= IX_MUL;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				IX_MUL: begin
					done_q  <= 1'b1;
					state_q <= IX_IDLE;
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= IX_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			IX_IDLE: begin
				if (req.go) begin
					dq_q  <= req.k;
					rem_q <= '0;
				end
			end
			IX_DIV: begin
				dq_q  <= {dq_q[ADDR_W-2:0], ge};
				rem_q <= rem_d;
			end
			IX_MUL: next_q <= sum[ADDR_W-1:0];
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.next = next_q;

endmodule

/* sv/inplace_matrix_transpose.sv */
// ----------------------------------------------------------------------------
// inplace_matrix_transpose
// Loads a matrix row-major, transposes it in place by cycle following and
// returns the transposed matrix row-major.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  req     | req_valid / req_stall | req_t: action, element_in
//  rsp     | rsp_valid / rsp_stall | rsp_t: element_out, last_of_matrix
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data (rows, cols)
//
//  The final load starts the transpose; every cycle-following step runs in the
//  shared divide and multiply unit; the swap of a rotated element overlaps its
//  step, and each start index adds a pass through ST_ADVANCE and each rotated
//  cycle one through ST_ROT_LOAD. req_stall and cfg_ready follow the busy
//  sequencer; req_stall also rises while cfg_valid is high, and a read also
//  stalls while a stalled result sits in the output register. Reset gives a
//  1 x 1 shape and an empty matrix; the store is not cleared.
// ----------------------------------------------------------------------------
module inplace_matrix_transpose import imt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data
);

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_CHECK    = 6'b000010,
		ST_ROT_LOAD = 6'b000100,
		ST_ROT_SWAP = 6'b001000,
		ST_ROT_WAIT = 6'b010000,
		ST_ADVANCE  = 6'b100000
	} state_t;

	state_t             state_q;
	logic [REG_W-1:0]   row_q;
	logic [REG_W-1:0]   col_q;
	logic [POS_W-1:0]   load_pos_q;
	logic [ADDR_W-1:0]  read_pos_q;
	logic               permuted_q;
	logic               chk_first_q;
	logic               out_valid_q;
	logic               out_last_q;
	logic [ELEM_W-1:0]  out_data_q;
	logic [ADDR_W-1:0]  start_q;
	logic [ADDR_W-1:0]  pos_q;
	logic [ADDR_W-1:0]  first_q;
	logic [ELEM_W-1:0]  carried_q;
	logic [ELEM_W-1:0]  rd_q;

	logic [ELEM_W-1:0]  mem [CAPACITY];

	shape_t             shape;
	ix_req_t            ix_req;
	ix_rsp_t            ix_rsp;
	logic [PROD_W-1:0]  total;
	logic [POS_W-1:0]   total_p;
	logic               shape_ok;
	logic               is_read;
	logic               req_acc;
	logic               cfg_acc;
	logic               cfg_hit;
	logic               rsp_take;
	logic               do_load;
	logic               do_read;
	logic [POS_W-1:0]   lp;
	logic [POS_W-1:0]   lp_inc;
	logic               load_last;
	logic               rp_last;
	logic [POS_W-1:0]   start_inc;
	logic               adv_done;
	logic [ADDR_W-1:0]  nxt;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [ELEM_W-1:0]  wr_data;
	logic [ADDR_W-1:0]  rd_addr;

	assign shape.rows = row_q;
	assign shape.cols = col_q;
	assign total      = PROD_W'(row_q) * PROD_W'(col_q);
	assign total_p    = total[POS_W-1:0];
	assign shape_ok   = (total != '0) && (total <= PROD_W'(CAPACITY));

	assign is_read   = (req.action == ACT_READ);
	assign req_stall = (state_q != ST_IDLE) || cfg_valid || (is_read && out_valid_q && rsp_stall);
	assign cfg_ready = (state_q == ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign cfg_hit   = cfg_acc && ((cfg_index == CFG_ROWS) || (cfg_index == CFG_COLS));
	assign rsp_take  = out_valid_q && !rsp_stall;
	assign do_load   = req_acc && !is_read && shape_ok;
	assign do_read   = req_acc && is_read && shape_ok && permuted_q;

	assign lp        = permuted_q ? '0 : load_pos_q;
	assign lp_inc    = lp + 1'b1;
	assign load_last = (lp_inc == total_p);
	assign rp_last   = ((POS_W'(read_pos_q) + 1'b1) == total_p);
	assign start_inc = POS_W'(start_q) + 1'b1;
	assign adv_done  = (start_inc == total_p);
	assign nxt       = ix_rsp.next;

	imt_index_unit u_index (
		.clk    (clk),
		.arst_n (arst_n),
		.shape  (shape),
		.req    (ix_req),
		.rsp    (ix_rsp)
	);

	always_comb begin
		ix_req.go = 1'b0;
		ix_req.k  = '0;
		rd_addr   = pos_q;
		wr_en     = 1'b0;
		wr_addr   = lp[ADDR_W-1:0];
		wr_data   = ELEM_W'(req.element_in);
		unique case (state_q)
			ST_IDLE: wr_en = do_load;
			ST_CHECK: begin
				rd_addr = start_q;
				if (ix_rsp.done && (nxt > start_q)) begin
					ix_req.go = 1'b1;
					ix_req.k  = nxt;
				end
			end
			ST_ROT_LOAD: begin
				ix_req.go = 1'b1;
				ix_req.k  = pos_q;
			end
			ST_ROT_SWAP: begin
				wr_en   = 1'b1;
				wr_addr = pos_q;
				wr_data = carried_q;
			end
			ST_ROT_WAIT: begin
				if (ix_rsp.done) begin
					if (nxt == start_q) begin
						wr_en   = 1'b1;
						wr_addr = start_q;
						wr_data = carried_q;
					end else begin
						rd_addr   = nxt;
						ix_req.go = 1'b1;
						ix_req.k  = nxt;
					end
				end
			end
			ST_ADVANCE: begin
				if (!adv_done) begin
					ix_req.go = 1'b1;
					ix_req.k  = start_inc[ADDR_W-1:0];
				end
			end
			default: ;
		endcase
	end

	// store: one write port, sequencer read port, readout port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
		if (do_read) begin
			out_data_q <= mem[read_pos_q];
			out_last_q <= rp_last;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (do_load && load_last) begin
					start_q <= '0;
				end
			end
			ST_CHECK: begin
				if (ix_rsp.done) begin
					if (chk_first_q) begin
						first_q <= nxt;
					end
					if ((nxt == start_q) && !chk_first_q) begin
						pos_q <= first_q;
					end
				end
			end
			ST_ROT_LOAD: carried_q <= rd_q;
			ST_ROT_SWAP: carried_q <= rd_q;
			ST_ROT_WAIT: begin
				if (ix_rsp.done) begin
					pos_q <= nxt;
				end
			end
			ST_ADVANCE: begin
				if (!adv_done) begin
					start_q <= start_inc[ADDR_W-1:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= REG_W'(1);
			col_q       <= REG_W'(1);
			load_pos_q  <= '0;
			read_pos_q  <= '0;
			permuted_q  <= 1'b0;
			chk_first_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_read) begin
				out_valid_q <= 1'b1;
			end else if (rsp_take) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_hit) begin
				if (cfg_index == CFG_ROWS) begin
					row_q <= cfg_data;
				end else begin
					col_q <= cfg_data;
				end
				load_pos_q <= '0;
				read_pos_q <= '0;
				permuted_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (do_load) begin
						permuted_q <= 1'b0;
						read_pos_q <= '0;
						load_pos_q <= lp_inc;
						if (load_last) begin
							state_q <= ST_ADVANCE;
						end
					end
					if (do_read) begin
						if (rp_last) begin
							permuted_q <= 1'b0;
							load_pos_q <= '0;
							read_pos_q <= '0;
						end else begin
							read_pos_q <= read_pos_q + 1'b1;
						end
					end
				end
				ST_CHECK: begin
					if (ix_rsp.done) begin
						chk_first_q <= 1'b0;
						if (nxt == start_q) begin
							// a fixed point needs no rotation; a closed cycle with start as its lowest index is rotated
							state_q <= chk_first_q ? ST_ADVANCE : ST_ROT_LOAD;
						end else if (nxt < start_q) begin
							state_q <= ST_ADVANCE;
						end
					end
				end
				ST_ROT_LOAD: state_q <= ST_ROT_SWAP;
				ST_ROT_SWAP: state_q <= ST_ROT_WAIT;
				ST_ROT_WAIT: begin
					if (ix_rsp.done) begin
						state_q <= (nxt == start_q) ? ST_ADVANCE : ST_ROT_SWAP;
					end
				end
				ST_ADVANCE: begin
					if (adv_done) begin
						permuted_q <= 1'b1;
						read_pos_q <= '0;
						state_q    <= ST_IDLE;
					end else begin
						chk_first_q <= 1'b1;
						state_q     <= ST_CHECK;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_valid          = out_valid_q;
	assign rsp.element_out    = FIELD_W'(out_data_q);
	assign rsp.last_of_matrix = out_last_q;

endmodule

/* sv/imt_checker.sv */
// ----------------------------------------------------------------------------
// imt_checker
// Port-level checks of the transpose block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module imt_checker import imt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp,
	input logic cfg_valid,
	input logic cfg_ready
);

	`IMT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result changed")
	`IMT_ASSERT_IMPL(a_rsp_cause, $rose(rsp_valid), $past(req_valid && !req_stall && req.action == ACT_READ), "result without read item")
	`IMT_ASSERT_IMPL(a_read_room, req_valid && !req_stall && req.action == ACT_READ, !(rsp_valid && rsp_stall), "read taken over a waiting result")
	`IMT_ASSERT_IMPL(a_busy_both, !req_stall, cfg_ready, "item taken while config port is busy")
	`IMT_ASSERT_IMPL(a_cfg_first, cfg_valid && cfg_ready, req_stall, "item taken with a register write")

endmodule

bind inplace_matrix_transpose imt_checker u_imt_checker (.*);

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the in-place matrix transpose. Matrices of many
// shapes are loaded row-major, read back and compared element by element
// against a transposed copy kept in the bench. Out-of-range shapes, early
// reads, abandoned readouts and register writes between matrices are covered
// under changing source and sink pacing.
// ----------------------------------------------------------------------------
module tb;
	import imt_pkg::*;

	localparam int RANDOM_ITEMS   = 610;
	localparam int SETTLE_CYCLES  = 40;
	localparam int DRAIN_CYCLES   = 40;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int PRINT_LIMIT    = 100;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = CFG_IDX_W'(3);

	typedef enum int {
		PACE_SLOW_SINK,
		PACE_SLOW_SOURCE,
		PACE_FREE
	} pace_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_t                 req       = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_t                 rsp;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0]     cfg_data  = '0;

	inplace_matrix_transpose i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// bench copy of the block state
	logic [ELEM_W-1:0] matrix_copy [CAPACITY];
	int unsigned       shape_rows  = 1;
	int unsigned       shape_cols  = 1;
	int unsigned       fill_index  = 0;
	int unsigned       drain_index = 0;
	bit                transposed  = 1'b0;

	req_t  pending_items[$];
	rsp_t  expected_elements[$];
	int    items_pushed   = 0;
	int    items_accepted = 0;
	int    mismatch_count = 0;
	int    quiet_cycles   = 0;
	pace_t pace           = PACE_SLOW_SINK;

	function automatic int unsigned dest_index(input int unsigned k);
		return (k % shape_cols) * shape_rows + k / shape_cols;
	endfunction

	function automatic void permute_copy(input int unsigned total);
		int unsigned       start;
		int unsigned       k;
		bit                lowest;
		logic [ELEM_W-1:0] carried;
		logic [ELEM_W-1:0] held;
		for (start = 1; start < total; start++) begin
			k = dest_index(start);
			lowest = 1'b1;
			while (k != start) begin
				if (k < start) begin
					lowest = 1'b0;
					break;
				end
				k = dest_index(k);
			end
			if (lowest) begin
				carried = matrix_copy[start];
				k = dest_index(start);
				while (k != start) begin
					held = matrix_copy[k];
					matrix_copy[k] = carried;
					carried = held;
					k = dest_index(k);
				end
				matrix_copy[start] = carried;
			end
		end
	endfunction

	function automatic void predict_readout(input req_t it);
		int unsigned total;
		rsp_t        r;
		total = shape_rows * shape_cols;
		if (total == 0 || total > CAPACITY)
			return;
		if (it.action == ACT_LOAD) begin
			if (transposed) begin
				transposed = 1'b0;
				drain_index = 0;
				fill_index = 0;
			end
			if (fill_index < total) begin
				matrix_copy[fill_index] = it.element_in;
				fill_index++;
				if (fill_index == total) begin
					permute_copy(total);
					transposed = 1'b1;
					drain_index = 0;
				end
			end
		end else if (transposed && drain_index < total) begin
			r.element_out = matrix_copy[drain_index];
			r.last_of_matrix = (drain_index + 1 == total);
			if (r.last_of_matrix) begin
				transposed = 1'b0;
				fill_index = 0;
				drain_index = 0;
			end else begin
				drain_index++;
			end
			expected_elements.push_back(r);
		end
	endfunction

	function automatic bit chance(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_LIMIT)
			$display("%0t: mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall) begin
				predict_readout(req);
				items_accepted++;
			end
			if (!req_valid || !req_stall) begin
				if (pending_items.size() != 0 && !chance((pace == PACE_SLOW_SINK) ? 20 :
						(pace == PACE_SLOW_SOURCE) ? 69 : 0)) begin
					req_valid <= 1'b1;
					req <= pending_items.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		rsp_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_elements.size() == 0) begin
					report_mismatch($sformatf("unexpected item %h", rsp));
				end else begin
					want = expected_elements.pop_front();
					if (rsp.element_out !== want.element_out)
						report_mismatch($sformatf("element_out %h, want %h",
							rsp.element_out, want.element_out));
					if (rsp.last_of_matrix !== want.last_of_matrix)
						report_mismatch($sformatf("last_of_matrix %b, want %b",
							rsp.last_of_matrix, want.last_of_matrix));
				end
			end
			rsp_stall <= chance((pace == PACE_SLOW_SINK) ? 69 :
				(pace == PACE_SLOW_SOURCE) ? 20 : 0);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("inplace_matrix_transpose regression: fail");
		$finish;
	end

	task automatic push_item(input action_t act, input logic [FIELD_W-1:0] data);
		req_t it;
		it.action = act;
		it.element_in = data;
		pending_items.push_back(it);
		items_pushed++;
	endtask

	// wait until every item is taken and every result has come back
	task automatic settle();
		@(posedge clk);
		while (items_accepted != items_pushed || expected_elements.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_ROWS || idx == CFG_COLS) begin
			if (idx == CFG_ROWS)
				shape_rows = data;
			else
				shape_cols = data;
			fill_index = 0;
			drain_index = 0;
			transposed = 1'b0;
		end
		@(posedge clk);
	endtask

	initial begin
		int          i;
		int          r;
		int          rounds;
		int          reads;
		int          pick;
		int          counted;
		int          mark;
		int unsigned rows;
		int unsigned cols;
		int unsigned total;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 1 x 1 after reset
		push_item(ACT_READ, $urandom());
		push_item(ACT_LOAD, 32'h0000_0000);
		push_item(ACT_READ, $urandom());
		push_item(ACT_LOAD, 32'hFFFF_FFFF);
		push_item(ACT_READ, 32'h0000_0000);
		push_item(ACT_READ, 32'hFFFF_FFFF);
		settle();

		// 2 x 3 with an early read, a spare index write mid-readout and a reload
		write_reg(CFG_ROWS, REG_W'(2));
		write_reg(CFG_COLS, REG_W'(3));
		for (i = 0; i < 6; i++) begin
			if (i == 3)
				push_item(ACT_READ, $urandom());
			push_item(ACT_LOAD, $urandom());
		end
		push_item(ACT_READ, $urandom());
		push_item(ACT_READ, $urandom());
		settle();
		write_reg(CFG_UNUSED_HI, REG_W'(11'h7FF));
		push_item(ACT_READ, $urandom());
		for (i = 0; i < 6; i++)
			push_item(ACT_LOAD, $urandom());
		repeat (6) push_item(ACT_READ, $urandom());
		settle();

		// shapes out of range
		write_reg(CFG_ROWS, REG_W'(0));
		push_item(ACT_LOAD, $urandom());
		push_item(ACT_READ, $urandom());
		settle();
		write_reg(CFG_ROWS, REG_W'(11'h7FF));
		push_item(ACT_LOAD, $urandom());
		push_item(ACT_READ, $urandom());
		settle();
		write_reg(CFG_ROWS, REG_W'(1024));
		write_reg(CFG_COLS, REG_W'(1024));
		write_reg(CFG_UNUSED_LO, REG_W'(0));
		push_item(ACT_LOAD, $urandom());
		push_item(ACT_READ, $urandom());

		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			pace = (counted < RANDOM_ITEMS / 3) ? PACE_SLOW_SINK :
				(counted < 2 * RANDOM_ITEMS / 3) ? PACE_SLOW_SOURCE : PACE_FREE;
			pick = $urandom_range(0, 19);
			if (pick < 12) begin
				rows = $urandom_range(1, 6);
				cols = $urandom_range(1, 6);
			end else if (pick < 16) begin
				rows = $urandom_range(1, 12);
				cols = $urandom_range(1, 12);
			end else if (pick < 18) begin
				if ($urandom_range(0, 1)) begin
					rows = 1;
					cols = $urandom_range(2, 40);
				end else begin
					rows = $urandom_range(2, 40);
					cols = 1;
				end
			end else if (pick < 19) begin
				rows = $urandom_range(9, 16);
				cols = $urandom_range(9, 16);
			end else if ($urandom_range(0, 1)) begin
				rows = 0;
				cols = $urandom_range(0, 2047);
			end else begin
				rows = $urandom_range(33, 2047);
				cols = $urandom_range(33, 2047);
			end
			settle();
			write_reg(CFG_ROWS, REG_W'(rows));
			write_reg(CFG_COLS, REG_W'(cols));
			total = rows * cols;
			if (total == 0 || total > CAPACITY) begin
				repeat (3) push_item(action_t'($urandom_range(0, 1)), $urandom());
				continue;
			end
			mark = items_pushed;
			rounds = ($urandom_range(0, 4) == 0) ? 2 : 1;
			for (r = 0; r < rounds; r++) begin
				for (i = 0; i < total; i++) begin
					if ($urandom_range(0, 15) == 0)
						push_item(ACT_READ, $urandom());
					push_item(ACT_LOAD, $urandom());
				end
				// a partial readout is cut short by the next load or register write
				if (r + 1 < rounds || $urandom_range(0, 5) == 0)
					reads = $urandom_range(0, total - 1);
				else
					reads = total + $urandom_range(0, 1);
				repeat (reads) push_item(ACT_READ, $urandom());
			end
			counted += items_pushed - mark;
		end

		@(posedge clk);
		while (items_accepted != items_pushed || expected_elements.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("inplace_matrix_transpose regression: pass");
		else
			$display("inplace_matrix_transpose regression: fail");
		$finish;
	end

endmodule

/* inplace_matrix_transpose.f */
+incdir+sv
sv/imt_pkg.sv
sv/imt_index_unit.sv
sv/inplace_matrix_transpose.sv
sv/imt_checker.sv
bench/tb.sv
